// ===== rtl/tkb_pkg.sv =====
// ----------------------------------------------------------------------------
// tkb_pkg
// Shared types, constants and helpers for the tent kernel blur unit.
// ----------------------------------------------------------------------------
package tkb_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 8;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int RES_WIDTH   = 1024;
    localparam int RES_HEIGHT  = 1024;

    // signed width for mirrored tap positions, covers twice the largest frame side
    localparam int MIR_W = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_RADIUS_X     = 2'd2,
        CFG_RADIUS_Y     = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAPS,
        S_FLUSH,
        S_LOAD,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic tap_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic produce;
        logic last_tap;
        logic div_done;
        logic out_free;
    } t_sts;

    // edge mirror with border repeat, then clamp into 0..n-1
    function automatic logic signed [MIR_W-1:0] mirror(
        input logic signed [MIR_W-1:0] j,
        input logic signed [MIR_W-1:0] n
    );
        logic signed [MIR_W-1:0] v;
        v = j;
        if (v < 0) begin
            v = -v - MIR_W'(1);
        end
        if (v >= n) begin
            v = (n <<< 1) - MIR_W'(1) - v;
        end
        if (v < 0) begin
            v = '0;
        end
        if (v >= n) begin
            v = n - MIR_W'(1);
        end
        return v;
    endfunction

endpackage

// ===== rtl/tent_kernel_blur_rgba_unit.sv =====
// ----------------------------------------------------------------------------
// tent_kernel_blur_rgba_unit
// Separable tent blur of an RGBA8 raster stream.
// ----------------------------------------------------------------------------
// Usage:
//   configure frame size and radii on the write port while idle; any write
//   starts a new frame. Pixel words enter in raster order on the input
//   channel (opcode pixel), followed by radius_y*width+radius_x drain words.
//   Output pixel k leaves after input word k+radius_y*width+radius_x.
// Sequence:
//   a word that produces no output is only accepted. A word that produces one
//   is accepted, then its (2rx+1)(2ry+1) taps are read from the line store (one
//   tap per cycle on the single read port), the sum is finished, the restoring
//   divider works through one quotient bit per accumulator bit, and the result
//   is loaded into the output register once that register is free.
// Reset:
//   position counters clear, width and height go to 1024, radii to 0; the
//   line store is not cleared and is only read where already written.
// Stall:
//   a finished result waits in the output register; the next input word is
//   still taken, and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module tent_kernel_blur_rgba_unit
    import tkb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_opcode,
    input  logic [7:0]             i_pixel_red,
    input  logic [7:0]             i_pixel_green,
    input  logic [7:0]             i_pixel_blue,
    input  logic [7:0]             i_pixel_alpha,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_out_red,
    output logic [7:0]             o_out_green,
    output logic [7:0]             o_out_blue,
    output logic [7:0]             o_out_alpha,
    output logic                   o_frame_last
);

    t_cmd cmd;
    t_sts sts;

    tkb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tkb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_pixel_red   (i_pixel_red),
        .i_pixel_green (i_pixel_green),
        .i_pixel_blue  (i_pixel_blue),
        .i_pixel_alpha (i_pixel_alpha),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha),
        .o_frame_last  (o_frame_last)
    );

endmodule

// ===== rtl/tkb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkb_ctrl
// Sequencer: accepts a word and, if it produces an output, walks the kernel
// taps, runs the divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module tkb_ctrl
    import tkb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.produce) begin
                    n_state = S_TAPS;
                end
            end
            S_TAPS: begin
                if (i_sts.last_tap) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_LOAD;
            S_LOAD:  n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_TAPS:  o_cmd.tap_step = 1'b1;
            S_FLUSH: o_cmd = '0;
            S_LOAD:  o_cmd.div_load = 1'b1;
            S_DIV:   o_cmd.div_step = !i_sts.div_done;
            S_OUT:   o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/tkb_datapath.sv =====
// ----------------------------------------------------------------------------
// tkb_datapath
// Line store, frame position counters, tap address generation, weighted
// accumulation, shared-step dividers and the output register.
// ----------------------------------------------------------------------------
module tkb_datapath
    import tkb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_opcode,
    input  logic [7:0]             i_pixel_red,
    input  logic [7:0]             i_pixel_green,
    input  logic [7:0]             i_pixel_blue,
    input  logic [7:0]             i_pixel_alpha,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [7:0]             o_out_red,
    output logic [7:0]             o_out_green,
    output logic [7:0]             o_out_blue,
    output logic [7:0]             o_out_alpha,
    output logic                   o_frame_last
);

    localparam int RING   = 2 * MAX_RADIUS + 2;
    localparam int LW     = $clog2(RING);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(2 * MAX_HEIGHT + 2 * MAX_RADIUS + 4);
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int TW     = RW + 1;
    localparam int WTW    = $clog2(MAX_RADIUS + 2);
    localparam int TOT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int LAG_W  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                   + MAX_RADIUS + 2);
    localparam int SQ_MAX = (MAX_RADIUS + 1) * (MAX_RADIUS + 1);
    localparam int SQ_W   = $clog2(SQ_MAX + 1);
    localparam longint DIV_MAX = longint'(SQ_MAX) * longint'(SQ_MAX);
    localparam int DIV_W  = $clog2(DIV_MAX + 1);
    localparam int ACC_W  = $clog2(DIV_MAX * 255 + 1);
    localparam int DCNT_W = $clog2(ACC_W + 1);
    localparam int DEPTH  = RING * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int RES_W  = (RES_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RES_WIDTH;
    localparam int RES_H  = (RES_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RES_HEIGHT;

    // configuration, kept already clamped
    logic [WW-1:0]    r_w;
    logic [HW-1:0]    r_h;
    logic [RW-1:0]    r_rx;
    logic [RW-1:0]    r_ry;
    logic [SQ_W-1:0]  r_sqx;
    logic [SQ_W-1:0]  r_sqy;
    logic [DIV_W-1:0] r_div;

    // frame position
    logic [CW-1:0]    r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [LW-1:0]    r_in_line;
    logic [POS_W-1:0] r_pos;
    logic [TOT_W-1:0] r_out_count;
    logic [CW-1:0]    r_out_col;
    logic [HW-1:0]    r_out_row;
    logic [LW-1:0]    r_out_line;

    // taps and accumulation
    logic signed [TW-1:0] r_dx;
    logic signed [TW-1:0] r_dy;
    logic [31:0]          mem [DEPTH];
    logic [31:0]          r_rdata;
    logic [2*WTW-1:0]     r_wxy;
    logic                 r_v1;
    logic [ACC_W-1:0]     r_acc [4];

    // divider
    logic [DIV_W-1:0]  r_rem [4];
    logic [ACC_W-1:0]  r_quo [4];
    logic [DCNT_W-1:0] r_dcnt;

    logic        r_out_valid;
    logic [7:0]  r_out_ch [4];
    logic        r_out_last;

    logic [10:0]          cfg_v;
    logic [3:0]           cfg_r;
    logic [LAG_W-1:0]     lag;
    logic [TOT_W-1:0]     total;
    logic                 restart;
    logic                 frame_done;
    logic                 col_wrap;
    logic                 out_col_wrap;
    logic signed [MIR_W-1:0] jc;
    logic signed [MIR_W-1:0] jr;
    logic signed [MIR_W-1:0] mcol;
    logic signed [MIR_W-1:0] mrow;
    logic signed [MIR_W-1:0] lsum;
    logic [LW-1:0]        rline;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic [TW-1:0]        adx;
    logic [TW-1:0]        ady;
    logic [WTW-1:0]       wx;
    logic [WTW-1:0]       wy;
    logic [31:0]          wword;

    assign cfg_v = i_cfg_data;
    assign cfg_r = cfg_v[3:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= WW'(RES_W);
            r_h  <= HW'(RES_H);
            r_rx <= '0;
            r_ry <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH: begin
                    if (cfg_v == '0) begin
                        r_w <= WW'(1);
                    end else if (int'(cfg_v) > MAX_WIDTH) begin
                        r_w <= WW'(MAX_WIDTH);
                    end else begin
                        r_w <= WW'(cfg_v);
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (cfg_v == '0) begin
                        r_h <= HW'(1);
                    end else if (int'(cfg_v) > MAX_HEIGHT) begin
                        r_h <= HW'(MAX_HEIGHT);
                    end else begin
                        r_h <= HW'(cfg_v);
                    end
                end
                CFG_RADIUS_X: begin
                    r_rx <= (int'(cfg_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_r);
                end
                CFG_RADIUS_Y: begin
                    r_ry <= (int'(cfg_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_r);
                end
                default: r_rx <= r_rx;
            endcase
        end
    end

    // lag and total are needed on the first word after a write
    assign lag   = LAG_W'(LAG_W'(r_ry) * LAG_W'(r_w)) + LAG_W'(r_rx);
    assign total = TOT_W'(TOT_W'(r_w) * TOT_W'(r_h));

    // divisor is registered through r_sqx/r_sqy and r_div, settled before any divide starts
    always_ff @(posedge i_clk) begin
        r_sqx   <= SQ_W'((SQ_W'(r_rx) + SQ_W'(1)) * (SQ_W'(r_rx) + SQ_W'(1)));
        r_sqy   <= SQ_W'((SQ_W'(r_ry) + SQ_W'(1)) * (SQ_W'(r_ry) + SQ_W'(1)));
        r_div   <= DIV_W'(DIV_W'(r_sqx) * DIV_W'(r_sqy));
    end

    assign col_wrap     = (WW'(r_in_col) + WW'(1)) == r_w;
    assign out_col_wrap = (WW'(r_out_col) + WW'(1)) == r_w;
    assign frame_done   = (r_out_count + TOT_W'(1)) >= total;
    assign restart      = i_cfg_we || (i_cmd.out_load && frame_done);

    // input position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_line <= '0;
            r_pos     <= '0;
        end else if (i_cmd.accept) begin
            r_pos <= r_pos + POS_W'(1);
            if (col_wrap) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + ROW_W'(1);
                r_in_line <= (int'(r_in_line) == RING - 1) ? '0 : r_in_line + LW'(1);
            end else begin
                r_in_col <= r_in_col + CW'(1);
            end
        end
    end

    // output position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_out_count <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_line  <= '0;
        end else if (i_cmd.out_load) begin
            r_out_count <= r_out_count + TOT_W'(1);
            if (out_col_wrap) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + HW'(1);
                r_out_line <= (int'(r_out_line) == RING - 1) ? '0 : r_out_line + LW'(1);
            end else begin
                r_out_col <= r_out_col + CW'(1);
            end
        end
    end

    assign o_sts.produce  = (POS_W'(lag) <= r_pos) && (r_out_count < total);
    assign o_sts.last_tap = (r_dx == TW'(r_rx)) && (r_dy == TW'(r_ry));
    assign o_sts.div_done = (r_dcnt == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // tap walk, row major over the kernel
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dx <= -$signed(TW'(r_rx));
            r_dy <= -$signed(TW'(r_ry));
        end else if (i_cmd.tap_step) begin
            if (r_dx == TW'(r_rx)) begin
                r_dx <= -$signed(TW'(r_rx));
                r_dy <= r_dy + TW'(1);
            end else begin
                r_dx <= r_dx + TW'(1);
            end
        end
    end

    // tap address: mirror both axes, map row onto the ring by its offset
    always_comb begin
        jc    = $signed(MIR_W'(r_out_col)) + MIR_W'(r_dx);
        jr    = $signed(MIR_W'(r_out_row)) + MIR_W'(r_dy);
        mcol  = mirror(jc, $signed(MIR_W'(r_w)));
        mrow  = mirror(jr, $signed(MIR_W'(r_h)));
        lsum  = $signed(MIR_W'(r_out_line)) + (mrow - $signed(MIR_W'(r_out_row)));
        if (lsum < 0) begin
            lsum = lsum + MIR_W'(RING);
        end else if (lsum >= MIR_W'(RING)) begin
            lsum = lsum - MIR_W'(RING);
        end
        rline = LW'(lsum);
        raddr = AW'(AW'(rline) * AW'(MAX_WIDTH)) + AW'(CW'(mcol));
        waddr = AW'(AW'(r_in_line) * AW'(MAX_WIDTH)) + AW'(r_in_col);
        adx   = (r_dx < 0) ? TW'(-r_dx) : TW'(r_dx);
        ady   = (r_dy < 0) ? TW'(-r_dy) : TW'(r_dy);
        wx    = WTW'(r_rx) + WTW'(1) - WTW'(adx);
        wy    = WTW'(r_ry) + WTW'(1) - WTW'(ady);
        wword = {i_pixel_alpha, i_pixel_blue, i_pixel_green, i_pixel_red};
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (t_opcode'(i_opcode) == OP_PIXEL)
                && (r_in_row < ROW_W'(r_h))) begin
            mem[waddr] <= wword;
        end
        if (i_cmd.tap_step) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tap_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_step) begin
            r_wxy <= (2*WTW)'(wx) * (2*WTW)'(wy);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 4; ch++) begin
            if (i_cmd.accept) begin
                r_acc[ch] <= '0;
            end else if (r_v1) begin
                r_acc[ch] <= r_acc[ch]
                           + ACC_W'(ACC_W'(r_wxy) * ACC_W'(r_rdata[8*ch +: 8]));
            end
        end
    end

    // restoring divide, one quotient bit per cycle on all four channels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_load) begin
            r_dcnt <= DCNT_W'(ACC_W);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 4; ch++) begin
            logic [DIV_W:0] sh;
            sh = {r_rem[ch], r_quo[ch][ACC_W-1]};
            if (i_cmd.div_load) begin
                r_rem[ch] <= '0;
                r_quo[ch] <= r_acc[ch];
            end else if (i_cmd.div_step) begin
                if (sh >= {1'b0, r_div}) begin
                    r_rem[ch] <= DIV_W'(sh - {1'b0, r_div});
                    r_quo[ch] <= {r_quo[ch][ACC_W-2:0], 1'b1};
                end else begin
                    r_rem[ch] <= sh[DIV_W-1:0];
                    r_quo[ch] <= {r_quo[ch][ACC_W-2:0], 1'b0};
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int ch = 0; ch < 4; ch++) begin
                r_out_ch[ch] <= r_quo[ch][7:0];
            end
            r_out_last <= (r_out_count + TOT_W'(1)) == total;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_red    = r_out_ch[0];
    assign o_out_green  = r_out_ch[1];
    assign o_out_blue   = r_out_ch[2];
    assign o_out_alpha  = r_out_ch[3];
    assign o_frame_last = r_out_last;

endmodule
